// ===== hdl/cal_pkg.sv =====
package cal_pkg;

  localparam int CMD_W   = 2;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIRST  = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_PAST  = 2'd3
  } status_t;

endpackage

// ===== hdl/cal_if.sv =====
interface cal_req_if;
  logic                            valid;
  logic                            ready;
  cal_pkg::cmd_t                   cmd;
  logic signed [cal_pkg::DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cal_rsp_if;
  logic                               valid;
  logic                               ready;
  cal_pkg::status_t                   status;
  logic signed [cal_pkg::DATA_W-1:0]  read_value;
  logic [cal_pkg::COUNT_W-1:0]        count;
  logic [cal_pkg::COUNT_W-1:0]        removed_count;

  modport source (output valid, output status, output read_value, output count,
                  output removed_count, input ready);
  modport sink   (input valid, input status, input read_value, input count,
                  input removed_count, output ready);
endinterface

// ===== hdl/cal_ram.sv =====
module cal_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds its value until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/compacting_array_list_top.sv =====
// Ordered list of signed 32-bit values held in a single-port-write, registered-read RAM of
// DEPTH entries. Insert, first and next go from acceptance to the final state and load
// their result into the output register there once it is free. Remove scans the stored
// entries through the RAM, one entry per cycle, and writes the survivors back in place.
// It loads its result from the final state after any scan, once the output is free. One
// item is worked on at a time; a new item is accepted the cycle after the previous result
// enters the output register, even while that result waits to be taken.
// The count fields report the entry count modulo 128.
module compacting_array_list_top #(
  parameter int DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  cal_req_if.sink        req,
  cal_rsp_if.source      rsp
);
  import cal_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t              state;
  cmd_t                cmd_r;
  logic [DATA_W-1:0]   val_r;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       cursor;
  logic [CW-1:0]       scan_rd;
  logic [CW-1:0]       wr;
  logic                pend;

  logic                ovalid;
  status_t             ostatus;
  logic [DATA_W-1:0]   ovalue;
  logic [COUNT_W-1:0]  ocount;
  logic [COUNT_W-1:0]  oremoved;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic                accept;
  logic                out_free;
  logic                issue;
  logic                keep;
  logic [CW:0]         cursor_inc;

  status_t             fin_status;
  logic [DATA_W-1:0]   fin_value;
  logic [CW-1:0]       fin_fill;
  logic [CW-1:0]       fin_cursor;
  logic [CW-1:0]       fin_removed;
  logic                fin_we;
  logic [CW+COUNT_W-1:0] fill_ext;
  logic [CW+COUNT_W-1:0] removed_ext;

  cal_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DATA_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign out_free   = !ovalid || rsp.ready;
  assign cursor_inc = {1'b0, cursor} + {{CW{1'b0}}, 1'b1};
  assign issue      = (state == S_SCAN) && (scan_rd < fill);
  assign keep       = (state == S_SCAN) && pend && (ram_rdata != val_r);

  always_comb begin
    fin_status  = ST_OK;
    fin_value   = '0;
    fin_fill    = fill;
    fin_cursor  = cursor;
    fin_removed = '0;
    fin_we      = 1'b0;
    case (cmd_r)
      CMD_INSERT: begin
        if (fill >= DEPTH_C) begin
          fin_status = ST_FULL;
        end else begin
          fin_we   = 1'b1;
          fin_fill = fill + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (fill == '0) begin
          fin_status = ST_EMPTY;
        end else begin
          fin_fill    = wr;
          fin_removed = fill - wr;
        end
      end
      CMD_FIRST: begin
        if (fill == '0) begin
          fin_status = ST_EMPTY;
        end else begin
          fin_cursor = '0;
          fin_value  = ram_rdata;
        end
      end
      CMD_NEXT: begin
        if (fill == '0) begin
          fin_status = ST_EMPTY;
          fin_cursor = '0;
        end else if (cursor_inc < {1'b0, fill}) begin
          fin_cursor = cursor_inc[CW-1:0];
          fin_value  = ram_rdata;
        end else begin
          fin_status = ST_PAST;
          fin_cursor = fill;
        end
      end
      default: begin
        fin_status = ST_OK;
      end
    endcase
    fill_ext    = {{COUNT_W{1'b0}}, fin_fill};
    removed_ext = {{COUNT_W{1'b0}}, fin_removed};
  end

  // RAM ports: the accept cycle reads for first and next, the scan reads ahead of the
  // compacting write, and the final step writes an appended value.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = val_r;
    if (accept && (req.cmd == CMD_FIRST)) begin
      ram_re = 1'b1;
    end else if (accept && (req.cmd == CMD_NEXT)) begin
      ram_re    = 1'b1;
      ram_raddr = cursor_inc[AW-1:0];
    end else if (issue) begin
      ram_re    = 1'b1;
      ram_raddr = scan_rd[AW-1:0];
    end
    if (keep) begin
      ram_we    = 1'b1;
      ram_waddr = wr[AW-1:0];
      ram_wdata = ram_rdata;
    end else if ((state == S_FIN) && out_free && fin_we) begin
      ram_we    = 1'b1;
      ram_waddr = fill[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      cursor  <= '0;
      ovalid  <= 1'b0;
      pend    <= 1'b0;
      scan_rd <= '0;
      wr      <= '0;
    end else begin
      if (rsp.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= req.cmd;
            val_r   <= req.value;
            scan_rd <= '0;
            wr      <= '0;
            pend    <= 1'b0;
            if ((req.cmd == CMD_REMOVE) && (fill != '0)) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          pend <= issue;
          if (issue) begin
            scan_rd <= scan_rd + 1'b1;
          end
          if (keep) begin
            wr <= wr + 1'b1;
          end
          if (!issue && !pend) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            fill     <= fin_fill;
            cursor   <= fin_cursor;
            ovalid   <= 1'b1;
            ostatus  <= fin_status;
            ovalue   <= fin_value;
            ocount   <= fill_ext[COUNT_W-1:0];
            oremoved <= removed_ext[COUNT_W-1:0];
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = ovalid;
  assign rsp.status        = ostatus;
  assign rsp.read_value    = ovalue;
  assign rsp.count         = ocount;
  assign rsp.removed_count = oremoved;

`ifndef SYNTHESIS
  // The compacting write never overtakes the scan read.
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (wr <= scan_rd))
    else $error("compaction write pointer passed the scan pointer");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("block stayed idle after accepting an item");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_free && (cmd_r == CMD_REMOVE) |=> (fill <= $past(fill)))
    else $error("remove grew the list");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_free && (cmd_r == CMD_INSERT) && (fill < DEPTH_C)
    |=> (fill == $past(fill) + 1'b1))
    else $error("insert did not add exactly one entry");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (fill <= DEPTH_C) && (wr <= fill))
    else $error("fill count or compaction pointer out of range");
`endif

endmodule
